[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file sre_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

[hw/rtl/sre_pkg.sv]
// ----------------------------------------------------------------------------
// sre_pkg
// Shared constants for the signed radix digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sre_pkg;

  // Default parameter values
  localparam int MaxRadixDef   = 16;
  localparam int ValueWidthDef = 32;

  // Fixed field widths
  localparam int InW      = 32;
  localparam int SymW     = 8;
  localparam int LenW     = 5;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 2;
  localparam int NumSyms  = 16;

  // Quotient bits resolved per divider cycle
  localparam int DivStep = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegRadixLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSymbolsLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSymbolsHigh = 2'd2;

  // Reserved characters
  localparam logic [SymW-1:0] SymPlus  = 8'h2B;
  localparam logic [SymW-1:0] SymMinus = 8'h2D;
  localparam logic [SymW-1:0] SymNul   = 8'h00;

endpackage

`default_nettype wire

[hw/rtl/signed_radix_digit_emitter.sv]
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter
// Converts one signed value into its text in a programmable radix.
// ----------------------------------------------------------------------------
// One value is taken at a time; in_stall_o stays high until the value's whole
// character run has been loaded into the output register. The magnitude is
// divided by the radix in a shared restoring divider that resolves 8 quotient
// bits a cycle. Each value passes through the accept, an alphabet check, the
// divider passes (one per digit, repeated until the quotient is zero), a sign
// step (which also issues the minus sign when needed) and an emit step for
// each digit; a stalled output holds the sign and digit steps. An invalid
// alphabet gives an empty run: the check returns the block to idle.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module signed_radix_digit_emitter
  import sre_pkg::*;
#(
  parameter int MAX_RADIX   = MaxRadixDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input channel
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [InW-1:0]      value_i,
  // output channel
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [SymW-1:0]     symbol_o,
  output      logic                last_o
);

  localparam int Chunks = (VALUE_WIDTH + DivStep - 1) / DivStep;
  localparam int DivW   = Chunks * DivStep;
  localparam int ChW    = (Chunks > 1) ? $clog2(Chunks) : 1;
  localparam int DigW   = $clog2(MAX_RADIX);
  localparam int IdxW   = $clog2(VALUE_WIDTH);
  localparam int CntW   = $clog2(VALUE_WIDTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // configuration registers
  logic [LenW-1:0]     len_q;
  logic [CfgDataW-1:0] sym_lo_q;
  logic [CfgDataW-1:0] sym_hi_q;

  logic [NumSyms-1:0][SymW-1:0] alpha;
  logic                         alpha_ok;

  // sequencer and datapath
  logic [2:0]      state_q, state_d;
  logic [DivW-1:0] div_q, div_d, div_nx;
  logic [DigW-1:0] rem_q, rem_d, rem_nx;
  logic [ChW-1:0]  chunk_q, chunk_d;
  logic [CntW-1:0] nd_q, nd_d, nd_dec;
  logic            neg_q, neg_d;
  logic [IdxW-1:0] wr_idx, rd_idx;
  logic            dig_we;
  logic [DigW-1:0] dig_q [VALUE_WIDTH];
  logic [3:0]      sym_idx;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [SymW-1:0] symbol_q, symbol_d;
  logic            last_q, last_d;
  logic            out_free;

  // input decode
  logic [VALUE_WIDTH-1:0] val_w;
  logic [VALUE_WIDTH-1:0] mag_w;
  logic                   val_neg;

  // divider step scratch
  logic [DigW-1:0]    r;
  logic [DigW:0]      t;
  logic [LenW-1:0]    t_ext;
  logic [DivStep-1:0] qbits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegRadixLength: len_q    <= cfg_data_i[LenW-1:0];
        RegSymbolsLow:  sym_lo_q <= cfg_data_i;
        RegSymbolsHigh: sym_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign alpha = {sym_hi_q, sym_lo_q};

  // Alphabet check: length range, reserved bytes and duplicates within the length
  always_comb begin
    alpha_ok = (len_q >= LenW'(2)) && (len_q <= LenW'(MAX_RADIX)) &&
               (len_q <= LenW'(NumSyms));
    for (int i = 0; i < NumSyms; i++) begin
      if (LenW'(i) < len_q) begin
        if (alpha[i] == SymNul || alpha[i] == SymPlus || alpha[i] == SymMinus) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < NumSyms; j++) begin
          if (LenW'(j) < len_q && alpha[j] == alpha[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign val_w   = value_i[VALUE_WIDTH-1:0];
  assign val_neg = val_w[VALUE_WIDTH-1];
  assign mag_w   = val_neg ? (VALUE_WIDTH'(0) - val_w) : val_w;

  // Shared divider: DivStep restoring steps on the narrow remainder
  always_comb begin
    r     = rem_q;
    t     = '0;
    t_ext = '0;
    qbits = '0;
    for (int k = 0; k < DivStep; k++) begin
      t     = {r, div_q[DivW-1-k]};
      t_ext = LenW'(t);
      if (t_ext >= len_q) begin
        qbits[DivStep-1-k] = 1'b1;
        r = DigW'(t_ext - len_q);
      end else begin
        r = t[DigW-1:0];
      end
    end
    div_nx = (div_q << DivStep) | DivW'(qbits);
    rem_nx = r;
  end

  assign nd_dec   = nd_q - CntW'(1);
  assign wr_idx   = nd_q[IdxW-1:0];
  assign rd_idx   = nd_dec[IdxW-1:0];
  assign sym_idx  = 4'(dig_q[rd_idx]);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    nd_d        = nd_q;
    neg_d       = neg_q;
    dig_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    symbol_d    = symbol_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          div_d   = DivW'(mag_w);
          neg_d   = val_neg;
          rem_d   = '0;
          chunk_d = '0;
          nd_d    = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = alpha_ok ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        div_d   = div_nx;
        rem_d   = rem_nx;
        chunk_d = chunk_q + ChW'(1);
        if (chunk_q == ChW'(Chunks - 1)) begin
          // digit done: store remainder, restart on the quotient
          dig_we  = 1'b1;
          nd_d    = nd_q + CntW'(1);
          rem_d   = '0;
          chunk_d = '0;
          if (div_nx == '0) begin
            state_d = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!neg_q) begin
          state_d = S_EMIT;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          symbol_d    = SymMinus;
          last_d      = 1'b0;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          symbol_d    = alpha[sym_idx];
          last_d      = (nd_q == CntW'(1));
          nd_d        = nd_dec;
          if (nd_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      chunk_q     <= '0;
      nd_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chunk_q     <= chunk_d;
      nd_q        <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q    <= div_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
    if (dig_we) begin
      dig_q[wr_idx] <= rem_nx;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[hw/rtl/sre_checker.sv]
// ----------------------------------------------------------------------------
// sre_checker
// Port-level assertions for the signed radix digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sre_checker
  import sre_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [SymW-1:0]     symbol_o,
  input wire logic                last_o
);

  logic in_beat;
  logic out_hold;
  logic sym_legal;

  assign in_beat   = in_valid_i && !in_stall_o;
  assign out_hold  = out_valid_o && out_stall_i;
  assign sym_legal = (symbol_o != SymNul) && (symbol_o != SymPlus);

  // A stalled output beat stays put
  `SRE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable({symbol_o, last_o}))

  // An accepted value blocks the input while it is converted
  `SRE_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat, in_stall_o)

  // Only validated alphabet bytes or the minus sign leave the block
  `SRE_ASSERT_IMPL(a_no_reserved_sym, clk_i, rst_ni, out_valid_o, sym_legal)

  // The minus sign always leads a run, never ends it
  `SRE_ASSERT_IMPL(a_minus_not_last, clk_i, rst_ni, out_valid_o && symbol_o == SymMinus, !last_o)

endmodule

bind signed_radix_digit_emitter sre_checker u_sre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .symbol_o    (symbol_o),
  .last_o      (last_o)
);

`default_nettype wire

[tb/sre_char_checker.sv]
// ----------------------------------------------------------------------------
// sre_char_checker
// Watches the configuration port and both channels of the radix digit
// emitter, works out the character run of every accepted value under the
// current alphabet, and compares each output beat with it in order.
// ----------------------------------------------------------------------------
module sre_char_checker
  import sre_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [InW-1:0]      value_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [SymW-1:0]     symbol_i,
  input  logic                last_i,
  input  logic                drain_done_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  chars_o
);

  localparam int PrintCap = 50;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
  } char_beat_t;

  char_beat_t          char_q[$];
  logic [LenW-1:0]     radix_len;
  logic [CfgDataW-1:0] syms_lo;
  logic [CfgDataW-1:0] syms_hi;
  int                  mismatches = 0;
  int                  chars_seen = 0;
  bit                  leftovers_checked = 1'b0;

  assign fail_count_o = mismatches;
  assign chars_o      = chars_seen;

  task automatic report_mismatch(input string what);
    if (mismatches < PrintCap) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [SymW-1:0] alpha_sym(input int unsigned k);
    return (k < 8) ? syms_lo[SymW*k +: SymW] : syms_hi[SymW*(k-8) +: SymW];
  endfunction

  function automatic bit alphabet_ok();
    logic [SymW-1:0] a;
    if (radix_len < 2 || radix_len > MaxRadixDef) return 1'b0;
    for (int i = 0; i < radix_len; i++) begin
      a = alpha_sym(i);
      if (a == SymNul || a == SymPlus || a == SymMinus) return 1'b0;
      for (int j = i + 1; j < radix_len; j++)
        if (alpha_sym(j) == a) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sign first, then digits most significant first; last rides on the final digit.
  task automatic predict_run(input logic [InW-1:0] v);
    logic [InW:0]  mag;
    logic [3:0]    digit_buf [InW+1];
    int unsigned   base;
    int unsigned   nd;
    char_beat_t    beat;
    if (!alphabet_ok()) return;
    base = radix_len;
    // widen so the most negative value has a representable magnitude
    mag = v[InW-1] ? ({1'b1, {InW{1'b0}}} - {1'b0, v}) : {1'b0, v};
    nd = 0;
    do begin
      digit_buf[nd] = 4'(mag % base);
      mag = mag / base;
      nd++;
    end while (mag != 0);
    if (v[InW-1]) begin
      beat.sym  = SymMinus;
      beat.last = 1'b0;
      char_q.push_back(beat);
    end
    while (nd > 0) begin
      nd--;
      beat.sym  = alpha_sym(digit_buf[nd]);
      beat.last = (nd == 0);
      char_q.push_back(beat);
    end
  endtask

  task automatic check_char();
    char_beat_t want;
    chars_seen++;
    if (char_q.size() == 0) begin
      report_mismatch($sformatf("unexpected character %h last %b", symbol_i, last_i));
      return;
    end
    want = char_q.pop_front();
    if (symbol_i !== want.sym)
      report_mismatch($sformatf("symbol %h, want %h", symbol_i, want.sym));
    if (last_i !== want.last)
      report_mismatch($sformatf("last %b, want %b (symbol %h)", last_i, want.last, want.sym));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_len = '0;
      syms_lo   = '0;
      syms_hi   = '0;
      char_q.delete();
    end else begin
      // drain the oldest expectation before adding the new value's run
      if (out_valid_i && !out_stall_i) check_char();
      if (in_valid_i && !in_stall_i) predict_run(value_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegRadixLength: radix_len = cfg_data_i[LenW-1:0];
          RegSymbolsLow:  syms_lo   = cfg_data_i;
          RegSymbolsHigh: syms_hi   = cfg_data_i;
          default: ;
        endcase
      end
      if (drain_done_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (char_q.size() != 0)
          report_mismatch($sformatf("%0d characters never arrived", char_q.size()));
      end
    end
    pending_o <= char_q.size();
  end

endmodule

[tb/signed_radix_digit_emitter_test.sv]
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_test
// Programs a series of digit alphabets, valid and broken, feeds signed values
// through the emitter with random pacing on both channels and one long output
// hold-off, and leaves the checking to sre_char_checker.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_test;
  import sre_pkg::*;

  typedef enum int {
    FlawShort,
    FlawLong,
    FlawNul,
    FlawPlus,
    FlawMinus,
    FlawRepeat
  } flaw_e;

  localparam int HoldCycles   = 400;
  localparam int QuietLimit   = 5000;
  localparam int SettleCycles = 20;
  localparam int TailCycles   = 200;
  localparam int RandomValues = 310;

  localparam logic [CfgIdxW-1:0]  RegSpare = 2'd3;
  localparam logic [CfgDataW-1:0] DecLo    = 64'h3736_3534_3332_3130;
  localparam logic [CfgDataW-1:0] DecHi    = 64'h2D2B_0000_4142_3938;
  localparam logic [CfgDataW-1:0] HexHi    = 64'h6665_6463_6261_3938;
  localparam logic [CfgDataW-1:0] BinLo    = 64'h2D2D_2B2B_0000_3130;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [InW-1:0]      value      = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [SymW-1:0]     symbol;
  logic                last;
  logic                drain_done = 1'b0;
  logic                hold_req   = 1'b0;

  int fail_count;
  int pending;
  int chars_checked;
  int quiet       = 0;
  int values_sent = 0;
  int settings    = 0;
  int rejected    = 0;
  int tx_pct      = 0;
  int rx_pct      = 0;
  bit calm        = 1'b0;
  bit hold_taken  = 1'b0;
  int hold_left   = 0;
  int burst_left  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  signed_radix_digit_emitter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .symbol_o    (symbol),
    .last_o      (last)
  );

  sre_char_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .symbol_i     (symbol),
    .last_i       (last),
    .drain_done_i (drain_done),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .chars_o      (chars_checked)
  );

  // Receiver pacing: one long hold-off on request, otherwise random bursts.
  always @(posedge clk) begin : rx_pacing
    logic stall_next;
    stall_next = 1'b0;
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      stall_next = 1'b1;
    end else if (!calm && rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
      burst_left = $urandom_range(0, 13);
      stall_next = 1'b1;
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin : watchdog
    wait (quiet >= QuietLimit);
    $display("timeout: no beat for %0d cycles", QuietLimit);
    $display("FAIL signed_radix_digit_emitter");
    $finish;
  end

  function automatic void put_sym(inout logic [CfgDataW-1:0] lo,
                                  inout logic [CfgDataW-1:0] hi,
                                  input int unsigned k, input logic [SymW-1:0] c);
    if (k < 8) lo[SymW*k +: SymW] = c;
    else hi[SymW*(k-8) +: SymW] = c;
  endfunction

  // Distinct legal symbols within the length, random bytes beyond it.
  function automatic void make_alphabet(input int unsigned len,
                                        output logic [CfgDataW-1:0] lo,
                                        output logic [CfgDataW-1:0] hi);
    logic [SymW-1:0] c;
    bit              taken [256];
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    for (int k = 0; k < len; k++) begin
      do c = SymW'($urandom_range(1, 255));
      while (taken[c] || c == SymPlus || c == SymMinus);
      taken[c] = 1'b1;
      put_sym(lo, hi, k, c);
    end
  endfunction

  function automatic void build_broken(input flaw_e flaw, output int unsigned len,
                                       output logic [CfgDataW-1:0] lo,
                                       output logic [CfgDataW-1:0] hi);
    int unsigned p;
    int unsigned q;
    case (flaw)
      FlawShort: begin
        len = $urandom_range(0, 1);
        make_alphabet(2, lo, hi);
      end
      FlawLong: begin
        len = $urandom_range(17, 31);
        make_alphabet(16, lo, hi);
      end
      default: begin
        len = $urandom_range(2, 16);
        make_alphabet(len, lo, hi);
        p = $urandom_range(0, len - 1);
        q = (p + $urandom_range(1, len - 1)) % len;
        case (flaw)
          FlawNul:   put_sym(lo, hi, p, SymNul);
          FlawPlus:  put_sym(lo, hi, p, SymPlus);
          FlawMinus: put_sym(lo, hi, p, SymMinus);
          default:   put_sym(lo, hi, p, q < 8 ? lo[SymW*q +: SymW] : hi[SymW*(q-8) +: SymW]);
        endcase
      end
    endcase
  endfunction

  function automatic logic [InW-1:0] rand_value();
    logic [InW-1:0] mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 40) - 20;
      6:          return $urandom_range(0, 2000) - 1000;
      7: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(InW-1){1'b0}}};
          1:       return {1'b0, {(InW-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: begin
        mag = $urandom >> $urandom_range(0, InW - 1);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  task automatic send_value(input logic [InW-1:0] v);
    if (!calm && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    values_sent++;
  endtask

  // Drop valid and wait for every predicted character to come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_alphabet(input int unsigned len, input logic [CfgDataW-1:0] lo,
                                  input logic [CfgDataW-1:0] hi, input bit usable);
    logic [CfgDataW-1:0] len_word;
    wait_idle();
    // a rejected value leaves no characters behind, so give it time to finish
    repeat (SettleCycles) @(posedge clk);
    len_word = {$urandom, $urandom};
    len_word[LenW-1:0] = LenW'(len);
    write_reg(RegSpare, {$urandom, $urandom});
    write_reg(RegRadixLength, len_word);
    write_reg(RegSymbolsLow, lo);
    write_reg(RegSymbolsHigh, hi);
    cfg_we <= 1'b0;
    settings++;
    if (!usable) rejected++;
  endtask

  initial begin : stimulus
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    int unsigned         len;
    int                  random_sent;
    int                  phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_pct = 30;
    rx_pct = 10;
    // registers still cleared: values go in, nothing comes out
    send_value(32'd7);
    send_value(32'h8000_0000);

    program_alphabet(10, DecLo, DecHi, 1'b1);
    send_value(32'd0);
    send_value(32'd1);
    send_value('1);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd10);
    send_value(32'hFFFF_FFF6);
    send_value(32'd123456789);

    program_alphabet(2, BinLo, '0, 1'b1);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    send_value(32'd5);

    program_alphabet(16, DecLo, HexHi, 1'b1);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value('1);
    send_value(32'hDEAD_BEEF);

    program_alphabet(1, DecLo, DecHi, 1'b0);
    send_value(32'd42);
    program_alphabet(31, DecLo, HexHi, 1'b0);
    send_value(32'd42);
    for (int f = 0; f <= int'(FlawRepeat); f++) begin
      build_broken(flaw_e'(f), len, lo, hi);
      program_alphabet(len, lo, hi, 1'b0);
      send_value(rand_value());
    end

    random_sent = 0;
    phase       = 0;
    while (random_sent < RandomValues) begin
      calm   = (random_sent >= RandomValues - 60);
      tx_pct = 25 * $urandom_range(0, 2);
      rx_pct = 6 * $urandom_range(0, 2);
      if (phase % 5 == 4) begin
        build_broken(flaw_e'($urandom_range(0, int'(FlawRepeat))), len, lo, hi);
        program_alphabet(len, lo, hi, 1'b0);
        repeat ($urandom_range(2, 5)) send_value(rand_value());
      end else begin
        case ($urandom_range(0, 3))
          0:       len = 2;
          1:       len = 16;
          default: len = $urandom_range(2, 16);
        endcase
        make_alphabet(len, lo, hi);
        program_alphabet(len, lo, hi, 1'b1);
        if (phase == 2) begin
          // keep offering values while the output is held off
          tx_pct = 0;
          hold_req <= 1'b1;
        end
        repeat ($urandom_range(15, 35)) begin
          send_value(rand_value());
          random_sent++;
        end
      end
      phase++;
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Converted %0d values under %0d alphabet settings (%0d rejected), radix 2 to 16.",
             values_sent, settings, rejected);
    $display("Checked %0d characters, with random pacing and a %0d-cycle output hold-off.",
             chars_checked, HoldCycles);
    if (fail_count == 0) begin
      $display("PASS signed_radix_digit_emitter");
    end else begin
      $display("FAIL signed_radix_digit_emitter");
    end
    $finish;
  end

endmodule
